>>> src/ezr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ezr_pkg
// Types and constants for the ZYX Euler angle to rotation matrix pipeline.
// ----------------------------------------------------------------------------
package ezr_pkg;

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
    } t_angles;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_matrix;

    localparam logic signed [15:0] PI_Q13      = 16'sd25736;
    localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [15:0] ONE_Q14     = 16'sd16384;

    // odd polynomial coefficients, Q28
    localparam logic signed [31:0] C0 = 32'sd268435456;
    localparam logic signed [31:0] C1 = -32'sd44739243;
    localparam logic signed [31:0] C2 = 32'sd2236962;
    localparam logic signed [31:0] C3 = -32'sd53261;
    localparam logic signed [31:0] C4 = 32'sd740;

endpackage : ezr_pkg
`default_nettype wire

>>> src/ezr_sincos.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ezr_sincos
// Pipelined sine or cosine of a folded Q3.13 angle via degree-9 odd
// polynomial (Horner form, Q28). At most one multiply per stage.
// ----------------------------------------------------------------------------
module ezr_sincos (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [15:0] i_angle,   // clamped, in [-pi, pi]
    input  wire logic               i_cos,     // 1: return cos
    output logic signed [15:0]      o_val      // Q2.14
);
    import ezr_pkg::*;

    localparam int NSTG = 7;

    // round v/2^28 half up, signed floor of (v + half) is the same thing
    function automatic logic signed [35:0] rnd28(input logic signed [63:0] v);
        logic signed [63:0] w;
        w = v + 64'sd134217728;
        return 36'(w >>> 28);
    endfunction

    function automatic logic signed [15:0] sat(input logic signed [63:0] v);
        logic signed [63:0] q;
        q = (v + 64'sd2199023255552) >>> 42;
        if (q > 64'sd16384)       return ONE_Q14;
        else if (q < -64'sd16384) return -ONE_Q14;
        return 16'(q);
    endfunction

    logic signed [16:0] b, a;
    logic signed [31:0] n_x;

    always_comb begin
        b = 17'(i_angle);
        if (i_cos) begin
            b = b + 17'(HALF_PI_Q13);
            if (b > 17'(PI_Q13)) b = b - 17'sd51472;
        end
        a = b;
        if (b > 17'(HALF_PI_Q13))       a = 17'(PI_Q13) - b;
        else if (b < -17'(HALF_PI_Q13)) a = -17'(PI_Q13) - b;
        n_x = 32'(a) <<< 15;
    end

    logic signed [31:0] r_x  [NSTG-1];
    logic signed [31:0] r_x2 [1:4];
    logic signed [35:0] r_p  [2:NSTG-2];
    logic signed [63:0] n_prod;
    logic signed [15:0] r_out;

    // stage 0: x; stage 1: x2; stages 2..5: Horner; stage 6: x*p
    // x2 rides along with the Horner terms so each step uses its own item
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x;
            for (int i = 1; i < NSTG - 1; i++) r_x[i] <= r_x[i-1];
            r_x2[1] <= 32'(rnd28(64'(r_x[0]) * 64'(r_x[0])));
            for (int i = 2; i <= 4; i++) r_x2[i] <= r_x2[i-1];
            r_p[2] <= C3 + rnd28(64'(r_x2[1]) * 64'(C4));
            r_p[3] <= C2 + rnd28(64'(r_x2[2]) * 64'(r_p[2]));
            r_p[4] <= C1 + rnd28(64'(r_x2[3]) * 64'(r_p[3]));
            r_p[5] <= C0 + rnd28(64'(r_x2[4]) * 64'(r_p[4]));
            r_out  <= sat(n_prod);
        end
    end

    assign n_prod = 64'(r_x[5]) * 64'(r_p[5]);

    assign o_val = r_out;

endmodule : ezr_sincos
`default_nettype wire

>>> src/euler_zyx_to_rotation_matrix_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// euler_zyx_to_rotation_matrix_unit
// ZYX Euler angles (Q3.13) to rotation matrix R = Rz*Ry*Rx (Q2.14).
//
//  channel | signals                        | payload
//  in      | i_in_valid / o_in_ready        | t_angles
//  out     | o_out_valid / i_out_ready      | t_matrix
//  cfg     | i_cfg_we / i_cfg_wdata         | rotation_enabled
//
// One item per cycle while the pipe is not held. Stages: clamp, 7-stage
// sine/cosine, two product stages, result register. The whole pipe advances
// together and holds while the output register is full and not taken.
// Synchronous active-low reset clears valid bits and sets rotation_enabled.
// ----------------------------------------------------------------------------
module euler_zyx_to_rotation_matrix_unit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_wdata,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire ezr_pkg::t_angles i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output ezr_pkg::t_matrix     o_out
);
    import ezr_pkg::*;

    localparam int LAT = 11;

    logic r_en_rot;
    logic [LAT-1:0] r_vld;
    logic adv;

    assign adv        = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready = adv;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_rot <= 1'b1;
            r_vld    <= '0;
        end else begin
            if (i_cfg_we) r_en_rot <= i_cfg_wdata;
            if (adv) r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    function automatic logic signed [15:0] clampa(input logic signed [15:0] a);
        if (a > PI_Q13)  return PI_Q13;
        if (a < -PI_Q13) return -PI_Q13;
        return a;
    endfunction

    logic signed [15:0] r_y, r_p, r_r;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_y <= clampa(i_in.yaw_angle);
            r_p <= clampa(i_in.pitch_angle);
            r_r <= clampa(i_in.roll_angle);
        end
    end

    logic signed [15:0] sy, cy, sp, cp, sr, cr;
    ezr_sincos u_sy (.i_clk, .i_en(adv), .i_angle(r_y), .i_cos(1'b0), .o_val(sy));
    ezr_sincos u_cy (.i_clk, .i_en(adv), .i_angle(r_y), .i_cos(1'b1), .o_val(cy));
    ezr_sincos u_sp (.i_clk, .i_en(adv), .i_angle(r_p), .i_cos(1'b0), .o_val(sp));
    ezr_sincos u_cp (.i_clk, .i_en(adv), .i_angle(r_p), .i_cos(1'b1), .o_val(cp));
    ezr_sincos u_sr (.i_clk, .i_en(adv), .i_angle(r_r), .i_cos(1'b0), .o_val(sr));
    ezr_sincos u_cr (.i_clk, .i_en(adv), .i_angle(r_r), .i_cos(1'b1), .o_val(cr));

    // stage A: pairwise Q28 products
    logic signed [31:0] r_cycp, r_sycp, r_cpsr, r_cpcr, r_cysp, r_sysp;
    logic signed [31:0] r_sycr, r_sysr, r_cycr, r_cysr;
    logic signed [15:0] r_sr, r_cr, r_sp;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cycp <= cy * cp;  r_sycp <= sy * cp;
            r_cpsr <= cp * sr;  r_cpcr <= cp * cr;
            r_cysp <= cy * sp;  r_sysp <= sy * sp;
            r_sycr <= sy * cr;  r_sysr <= sy * sr;
            r_cycr <= cy * cr;  r_cysr <= cy * sr;
            r_sr <= sr; r_cr <= cr; r_sp <= sp;
        end
    end

    function automatic logic signed [15:0] rs(input logic signed [47:0] v,
                                              input int n);
        logic signed [47:0] q;
        q = (v + (48'sd1 <<< (n - 1))) >>> n;
        if (q > 48'sd16384)       return ONE_Q14;
        else if (q < -48'sd16384) return -ONE_Q14;
        return 16'(q);
    endfunction

    // stage B: Q42 triple terms, summed and rounded once
    logic signed [47:0] t01, t02, t11, t12;
    assign t01 = 48'(r_cysp) * 48'(r_sr) - (48'(r_sycr) <<< 14);
    assign t02 = 48'(r_cysp) * 48'(r_cr) + (48'(r_sysr) <<< 14);
    assign t11 = 48'(r_sysp) * 48'(r_sr) + (48'(r_cycr) <<< 14);
    assign t12 = 48'(r_sysp) * 48'(r_cr) - (48'(r_cysr) <<< 14);

    t_matrix r_m, r_out;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m.m00 <= rs(48'(r_cycp), 14);
            r_m.m01 <= rs(t01, 28);
            r_m.m02 <= rs(t02, 28);
            r_m.m10 <= rs(48'(r_sycp), 14);
            r_m.m11 <= rs(t11, 28);
            r_m.m12 <= rs(t12, 28);
            r_m.m20 <= -r_sp;
            r_m.m21 <= rs(48'(r_cpsr), 14);
            r_m.m22 <= rs(48'(r_cpcr), 14);
            r_out <= r_en_rot ? r_m
                   : '{m00: ONE_Q14, m11: ONE_Q14, m22: ONE_Q14, default: '0};
        end
    end
    assign o_out = r_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out) && o_out_valid)
        else $error("output changed while stalled");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("stall without pending result");
    a_m20: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.m20 >= -ONE_Q14 && o_out.m20 <= ONE_Q14)
        else $error("m20 out of range");

endmodule : euler_zyx_to_rotation_matrix_unit
`default_nettype wire

>>> test/euler_zyx_to_rotation_matrix_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euler_zyx_to_rotation_matrix_unit_test
// Streams ZYX Euler angle triples through the rotation matrix unit with
// random idling on both sides, predicts each matrix in fixed point (or uses
// a known one) and compares whole matrices. Covers both settings of the
// rotation-enable register, angle clamping and the identity case.
// ----------------------------------------------------------------------------
module euler_zyx_to_rotation_matrix_unit_test;
    import ezr_pkg::*;

    localparam int PIPE_DEPTH = 11;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_cfg_we = 1'b0;
    logic     i_cfg_wdata = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_angles  i_in = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_matrix  o_out;

    euler_zyx_to_rotation_matrix_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    t_matrix  matrix_queue[$];
    bit       rot_en = 1'b1;
    int       mismatches = 0;
    bit       no_idle = 1'b0;

    // ---------------- predictor ----------------
    function automatic longint rnd_shift(longint v, int n);
        longint w;
        w = v + (longint'(1) << (n - 1));
        if (w >= 0) return w >>> n;
        return -(((-w) + (longint'(1) << n) - 1) >>> n);
    endfunction

    function automatic longint sat14(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    function automatic longint sine_q14(longint a);
        longint x, x2, p;
        longint coef[5];
        coef[0] = C0; coef[1] = C1; coef[2] = C2; coef[3] = C3; coef[4] = C4;
        if (a > HALF_PI_Q13) a = PI_Q13 - a;
        else if (a < -HALF_PI_Q13) a = -PI_Q13 - a;
        x = a * 32768;
        x2 = rnd_shift(x * x, 28);
        p = coef[4];
        for (int i = 3; i >= 0; i--) p = coef[i] + rnd_shift(x2 * p, 28);
        return sat14(rnd_shift(x * p, 42));
    endfunction

    function automatic longint cosine_q14(longint a);
        longint b;
        b = a + HALF_PI_Q13;
        if (b > PI_Q13) b -= 2 * PI_Q13;
        return sine_q14(b);
    endfunction

    function automatic longint clamp_pi(logic signed [15:0] a);
        longint v;
        v = a;
        if (v > PI_Q13) return PI_Q13;
        if (v < -PI_Q13) return -PI_Q13;
        return v;
    endfunction

    function automatic longint mul2(longint u, longint v);
        return sat14(rnd_shift(u * v, 14));
    endfunction

    function automatic longint mul3(longint u, longint v, longint w,
                                    longint p, longint q, bit add);
        longint acc, t;
        acc = u * v * w;
        t = p * q * 16384;
        acc = add ? acc + t : acc - t;
        return sat14(rnd_shift(acc, 28));
    endfunction

    function automatic t_matrix rotation_of(t_angles a, bit en);
        t_matrix m;
        longint sy, cy, sp, cp, sr, cr, y, p, r;
        m = '0;
        if (!en) begin
            m.m00 = ONE_Q14; m.m11 = ONE_Q14; m.m22 = ONE_Q14;
            return m;
        end
        y = clamp_pi(a.yaw_angle); p = clamp_pi(a.pitch_angle); r = clamp_pi(a.roll_angle);
        sy = sine_q14(y); cy = cosine_q14(y);
        sp = sine_q14(p); cp = cosine_q14(p);
        sr = sine_q14(r); cr = cosine_q14(r);
        m.m00 = 16'(mul2(cy, cp));
        m.m01 = 16'(mul3(cy, sp, sr, sy, cr, 1'b0));
        m.m02 = 16'(mul3(cy, sp, cr, sy, sr, 1'b1));
        m.m10 = 16'(mul2(sy, cp));
        m.m11 = 16'(mul3(sy, sp, sr, cy, cr, 1'b1));
        m.m12 = 16'(mul3(sy, sp, cr, cy, sr, 1'b0));
        m.m20 = 16'(-sp);
        m.m21 = 16'(mul2(cp, sr));
        m.m22 = 16'(mul2(cp, cr));
        return m;
    endfunction

    // ---------------- output side ----------------
    always @(posedge i_clk) begin
        t_matrix want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (matrix_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected matrix %h", o_out);
            end else begin
                want = matrix_queue.pop_front();
                if (o_out !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, o_out);
                end
            end
        end
        i_out_ready <= no_idle || ($urandom_range(99) >= 21);
    end

    // ---------------- input side ----------------
    // valid stays high from one transfer to the next unless an idle cycle comes
    task automatic send_angles(t_angles a, bit has_known, t_matrix known);
        while (!no_idle && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in <= a;
        i_in_valid <= 1'b1;
        if (has_known) matrix_queue.push_back(known);
        else matrix_queue.push_back(rotation_of(a, rot_en));
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic write_enable(bit v);
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (matrix_queue.size() != 0 && waited < 100000) begin
            @(posedge i_clk); waited++;
        end
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rot_en = v;
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return 16'(PI_Q13 - $urandom_range(3));
            2: return 16'(-PI_Q13 + $urandom_range(3));
            3: return 16'(HALF_PI_Q13 + $urandom_range(6) - 3);
            4: return 16'(-HALF_PI_Q13 + $urandom_range(6) - 3);
            default: return 16'($urandom_range(2 * 25736) - 25736);
        endcase
    endfunction

    typedef struct {
        logic signed [15:0] y, p, r;
        bit has_known;
    } t_row;

    t_row    rows[$];
    t_matrix ident;
    t_matrix zero_rot;

    initial begin
        t_angles a;
        ident = '0; ident.m00 = ONE_Q14; ident.m11 = ONE_Q14; ident.m22 = ONE_Q14;
        zero_rot = ident;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero angles give identity; extremes and clamping
        rows.push_back('{16'sd0, 16'sd0, 16'sd0, 1'b1});
        rows.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0});
        rows.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 1'b0});
        rows.push_back('{16'sd25736, -16'sd25736, 16'sd25737, 1'b0});
        rows.push_back('{-16'sd25737, 16'sd12868, -16'sd12868, 1'b0});
        rows.push_back('{16'sd12868, 16'sd12869, 16'sd12867, 1'b0});
        rows.push_back('{-16'sd1, 16'sd1, 16'sh5555, 1'b0});
        rows.push_back('{16'shaaaa, 16'sh2aaa, -16'sd12869, 1'b0});
        rows.push_back('{16'sd6434, 16'sd6434, 16'sd6434, 1'b0});
        foreach (rows[i]) begin
            a.yaw_angle = rows[i].y; a.pitch_angle = rows[i].p; a.roll_angle = rows[i].r;
            send_angles(a, rows[i].has_known, zero_rot);
        end

        // disabled: identity whatever the angles
        write_enable(1'b0);
        a = '{16'sh7fff, 16'sh8000, 16'sd12868};
        send_angles(a, 1'b1, ident);
        a = '{-16'sd25736, 16'sd25736, -16'sd1};
        send_angles(a, 1'b1, ident);
        write_enable(1'b1);

        for (int n = 0; n < 1050; n++) begin
            if (n == 300) write_enable(1'b0);
            if (n == 400) write_enable(1'b1);
            no_idle = (n >= 600 && n < 750);
            a.yaw_angle = rand_angle();
            a.pitch_angle = rand_angle();
            a.roll_angle = rand_angle();
            send_angles(a, 1'b0, ident);
        end
        i_in_valid <= 1'b0;
        no_idle = 1'b1;
        for (int w = 0; w < 100000 && matrix_queue.size() != 0; w++) @(posedge i_clk);
        repeat (PIPE_DEPTH + 5) @(posedge i_clk);
        if (mismatches == 0 && matrix_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
